// ===== rtl/core/biquad_cascade_band_pass_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the band-pass biquad cascade
// Shared forms for concurrent checks on the rising edge of clk_i.
// ----------------------------------------------------------------------------
`ifndef BIQUAD_CASCADE_BAND_PASS_MACROS_SVH
`define BIQUAD_CASCADE_BAND_PASS_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define BQC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define BQC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bqc_pkg.sv =====
// ----------------------------------------------------------------------------
// bqc_pkg
// Widths, register indexes, shared types and saturation helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bqc_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 16;
  localparam int DELAY_W    = 40;
  localparam int ACC_W      = 42;
  localparam int NUM_REG_W  = 48;
  localparam int DEN_REG_W  = 32;
  localparam int CFG_W      = 48;
  localparam int CFG_ADDR_W = 3;
  localparam int CNT_W      = $clog2(COEF_W);

  localparam logic [CFG_ADDR_W-1:0] REG_LOW_NUM  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LOW_DEN  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_HIGH_NUM = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_HIGH_DEN = 3'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } mac_stat_t;

  // Numerator word k; words past the third read as zero.
  function automatic logic signed [COEF_W-1:0] num_word(input logic [NUM_REG_W-1:0] r,
                                                        input logic [2:0] k);
    logic signed [COEF_W-1:0] w;
    case (k)
      3'd0:    w = r[15:0];
      3'd1:    w = r[31:16];
      3'd2:    w = r[47:32];
      default: w = '0;
    endcase
    return w;
  endfunction

  // Denominator word k; words past the second read as zero.
  function automatic logic signed [COEF_W-1:0] den_word(input logic [DEN_REG_W-1:0] r,
                                                        input logic [2:0] k);
    logic signed [COEF_W-1:0] w;
    case (k)
      3'd0:    w = r[15:0];
      3'd1:    w = r[31:16];
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [ACC_W-1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if ((&v[ACC_W-1:SAMPLE_W-1]) || !(|v[ACC_W-1:SAMPLE_W-1])) begin
      r = v[SAMPLE_W-1:0];
    end else begin
      r = v[ACC_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [DELAY_W-1:0] sat_delay(input logic signed [ACC_W-1:0] v);
    logic signed [DELAY_W-1:0] r;
    if ((&v[ACC_W-1:DELAY_W-1]) || !(|v[ACC_W-1:DELAY_W-1])) begin
      r = v[DELAY_W-1:0];
    end else begin
      r = v[ACC_W-1] ? {1'b1, {(DELAY_W-1){1'b0}}} : {1'b0, {(DELAY_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/bqc_mac.sv =====
// ----------------------------------------------------------------------------
// bqc_mac
// Bit-serial dual multiply-accumulate: init + x*b - y*a, one coefficient bit
// per cycle, most significant bit first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bqc_mac (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start_i,
  input  logic signed [bqc_pkg::SAMPLE_W-1:0]      x_i,
  input  logic signed [bqc_pkg::SAMPLE_W-1:0]      y_i,
  input  logic signed [bqc_pkg::COEF_W-1:0]        b_i,
  input  logic signed [bqc_pkg::COEF_W-1:0]        a_i,
  input  logic signed [bqc_pkg::ACC_W-1:0]         init_i,
  output bqc_pkg::mac_stat_t                       stat_o,
  output logic signed [bqc_pkg::ACC_W-1:0]         sum_o
);
  import bqc_pkg::*;

  logic [COEF_W-1:0]       bsh_q, ash_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [ACC_W-1:0] sum_q;
  logic [CNT_W-1:0]        cnt_q;
  logic                    busy_q, fin_q, done_q;
  logic signed [ACC_W-1:0] xe, ye, tx, ty, shifted;

  always_comb begin
    xe      = {{(ACC_W-SAMPLE_W){x_i[SAMPLE_W-1]}}, x_i};
    ye      = {{(ACC_W-SAMPLE_W){y_i[SAMPLE_W-1]}}, y_i};
    tx      = bsh_q[COEF_W-1] ? xe : '0;
    ty      = ash_q[COEF_W-1] ? ye : '0;
    shifted = {acc_q[ACC_W-2:0], 1'b0};
    // sign bit of a two's complement coefficient carries negative weight
    if (cnt_q == '0) begin
      acc_d = shifted - tx + ty;
    end else begin
      acc_d = shifted + tx - ty;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(COEF_W - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      bsh_q <= b_i;
      ash_q <= a_i;
      acc_q <= '0;
    end else if (busy_q) begin
      bsh_q <= {bsh_q[COEF_W-2:0], 1'b0};
      ash_q <= {ash_q[COEF_W-2:0], 1'b0};
      acc_q <= acc_d;
    end
    if (fin_q) begin
      sum_q <= acc_q + init_i;
    end
  end

  assign stat_o.busy = busy_q | fin_q;
  assign stat_o.done = done_q;
  assign sum_o       = sum_q;

endmodule

// ===== rtl/core/biquad_cascade_band_pass.sv =====
// ----------------------------------------------------------------------------
// biquad_cascade_band_pass
// Band-pass filter: low-pass biquad followed by high-pass biquad, transposed
// direct form II, bit-serial arithmetic.
// ----------------------------------------------------------------------------
// Each accepted 24-bit signed sample runs through a low-pass and then a
// high-pass second-order section; the result is rounded half up and saturated
// to 24 bits, and every delay register saturates to 40 bits. All arithmetic
// goes through one bit-serial multiply-accumulate unit that walks the 16 bits
// of a coefficient pair per operation; an operation steps through load, the
// coefficient bits, final sum and handoff. A section needs FILTER_ORDER+1
// operations. The block takes one sample at a time; the next sample is
// accepted while the previous result still waits in the output register, and
// delays reset to zero. Coefficients are to be written through the plain
// write port only while the block is idle; the user is bound by this, as the
// block itself does not enforce it.
`timescale 1ns / 1ps

module biquad_cascade_band_pass #(
  parameter int FILTER_ORDER   = 2,
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [bqc_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [bqc_pkg::CFG_W-1:0]          cfg_wdata_i,
  // sample requests in
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [bqc_pkg::SAMPLE_W-1:0]       s_axis_tdata_i,  // [23:0] sample_in
  // filtered samples out
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [bqc_pkg::SAMPLE_W-1:0]       m_axis_tdata_o   // [23:0] sample_out
);
  import bqc_pkg::*;

  localparam int OP_W   = $clog2(FILTER_ORDER + 1);
  localparam int DIDX_W = (FILTER_ORDER > 1) ? $clog2(FILTER_ORDER) : 1;
  localparam logic [ACC_W-1:0] ROUND_C = ACC_W'(64'd1 << (COEF_FRAC_BITS - 1));

  // coefficient registers, index 0 low-pass, 1 high-pass
  logic [NUM_REG_W-1:0] num_q [2];
  logic [DEN_REG_W-1:0] den_q [2];

  // section delay lines
  logic signed [DELAY_W-1:0] d_q [2][FILTER_ORDER];

  state_e                     state_q, state_d;
  logic signed [SAMPLE_W-1:0] x_q, x_d, y_q, y_d;
  logic                       sec_q, sec_d;
  logic [OP_W-1:0]            op_q, op_d;
  logic                       start_q, start_d;
  logic                       out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0]        out_data_q, out_data_d;

  logic                       d_we;
  logic [OP_W-1:0]            d_waddr;
  logic signed [DELAY_W-1:0]  d_wdata;

  mac_stat_t                  mac_stat;
  logic signed [ACC_W-1:0]    mac_sum, mac_init, shifted_sum;
  logic signed [COEF_W-1:0]   coef_b, coef_a;
  logic signed [DELAY_W-1:0]  d_rd;
  logic signed [SAMPLE_W-1:0] y_new;
  logic                       last_op;

  // Operand selection for the current operation. Operation 0 forms the
  // section output; operation i (i >= 1) rebuilds delay i-1.
  always_comb begin
    coef_b  = num_word(num_q[sec_q], 3'(op_q));
    coef_a  = (op_q == '0) ? '0 : den_word(den_q[sec_q], 3'(OP_W'(op_q - 1'b1)));
    d_rd    = d_q[sec_q][op_q[DIDX_W-1:0]];
    last_op = (op_q == OP_W'(FILTER_ORDER));
    if (op_q == '0) begin
      mac_init = {{(ACC_W-DELAY_W){d_rd[DELAY_W-1]}}, d_rd} + ROUND_C;
    end else if (!last_op) begin
      mac_init = {{(ACC_W-DELAY_W){d_rd[DELAY_W-1]}}, d_rd};
    end else begin
      mac_init = '0;
    end
    shifted_sum = mac_sum >>> COEF_FRAC_BITS;
    y_new       = sat_sample(shifted_sum);
    d_wdata     = sat_delay(mac_sum);
    d_waddr     = OP_W'(op_q - 1'b1);
  end

  bqc_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .x_i     (x_q),
    .y_i     (y_q),
    .b_i     (coef_b),
    .a_i     (coef_a),
    .init_i  (mac_init),
    .stat_o  (mac_stat),
    .sum_o   (mac_sum)
  );

  // Sequencer: next state and handshake outputs.
  always_comb begin
    state_d         = state_q;
    x_d             = x_q;
    y_d             = y_q;
    sec_d           = sec_q;
    op_d            = op_q;
    start_d         = 1'b0;
    d_we            = 1'b0;
    out_valid_d     = out_valid_q & ~m_axis_tready_i;
    out_data_d      = out_data_q;
    s_axis_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          x_d     = s_axis_tdata_i;
          sec_d   = 1'b0;
          op_d    = '0;
          start_d = 1'b1;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (mac_stat.done) begin
          if (op_q == '0) begin
            y_d = y_new;
          end else begin
            d_we = 1'b1;
          end
          if (!last_op) begin
            op_d    = op_q + 1'b1;
            start_d = 1'b1;
          end else if (!sec_q) begin
            // low-pass output feeds the high-pass section
            x_d     = y_q;
            sec_d   = 1'b1;
            op_d    = '0;
            start_d = 1'b1;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = y_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sec_q       <= 1'b0;
      op_q        <= '0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int s = 0; s < 2; s++) begin
        num_q[s] <= '0;
        den_q[s] <= '0;
        for (int i = 0; i < FILTER_ORDER; i++) begin
          d_q[s][i] <= '0;
        end
      end
    end else begin
      state_q     <= state_d;
      sec_q       <= sec_d;
      op_q        <= op_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
      if (d_we) begin
        d_q[sec_q][d_waddr[DIDX_W-1:0]] <= d_wdata;
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_LOW_NUM:  num_q[0] <= cfg_wdata_i[NUM_REG_W-1:0];
          REG_LOW_DEN:  den_q[0] <= cfg_wdata_i[DEN_REG_W-1:0];
          REG_HIGH_NUM: num_q[1] <= cfg_wdata_i[NUM_REG_W-1:0];
          REG_HIGH_DEN: den_q[1] <= cfg_wdata_i[DEN_REG_W-1:0];
          default: begin
            // drop writes to unknown indexes
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    y_q        <= y_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// ===== rtl/core/bqc_checker.sv =====
// ----------------------------------------------------------------------------
// bqc_checker
// Port-level checks of the band-pass cascade, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "biquad_cascade_band_pass_macros.svh"

module bqc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid_i,
  input logic                         s_axis_tready_o,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [bqc_pkg::SAMPLE_W-1:0] m_axis_tdata_o
);
  import bqc_pkg::*;

  // a stalled result holds
  `BQC_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled result changed")

  // one sample at a time: ready drops after a request is taken
  `BQC_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "ready held after accept")

  // ready returns only together with a finished result
  `BQC_ASSERT_NOW(a_ready_with_result, $rose(s_axis_tready_o), m_axis_tvalid_o, "ready rose without result")

  // a new result appears only at the end of processing
  `BQC_ASSERT_NOW(a_result_from_busy, $rose(m_axis_tvalid_o), $past(!s_axis_tready_o), "result rose while idle")

endmodule

bind biquad_cascade_band_pass bqc_checker u_bqc_checker (.*);
